// ----- rtl/core/range_list_consolidator_defines.svh -----
// assertion macros for the range list consolidator
`ifndef RANGE_LIST_CONSOLIDATOR_DEFINES_SVH
`define RANGE_LIST_CONSOLIDATOR_DEFINES_SVH

`ifndef SYNTH
`define RCL_ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rcl assertion failed");
`define RCL_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rcl assertion failed");
`else
`define RCL_ASSERT_IMPLIES(label, ck, rn, ante, cons)
`define RCL_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

// ----- rtl/core/rcl_pkg.sv -----
package rcl_pkg;

    localparam int BOUND_W = 31;

    typedef struct packed {
        logic [BOUND_W-1:0] range_lo;
        logic [BOUND_W-1:0] range_hi;
        logic               is_last_in;
    } rcl_in_t;

    typedef struct packed {
        logic [BOUND_W-1:0] merged_lo;
        logic [BOUND_W-1:0] merged_hi;
        logic               is_last_out;
        logic               is_empty;
        logic               overflowed;
    } rcl_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_MRG_RD,
        ST_MRG_CMP,
        ST_MRG_EMIT,
        ST_MRG_LAST,
        ST_EMPTY
    } rcl_state_t;

    typedef struct packed {
        logic load_item;
        logic ins_start;
        logic ins_read;
        logic ins_shift;
        logic ins_place;
        logic set_ovf;
        logic mrg_start;
        logic mrg_read;
        logic mrg_advance;
        logic run_load;
        logic run_ext;
        logic emit;
        logic emit_last;
        logic emit_empty;
        logic clear;
    } rcl_cmd_t;

    typedef struct packed {
        logic item_ok;
        logic item_last;
        logic full;
        logic count_zero;
        logic pos_zero;
        logic shift_needed;
        logic idx_first;
        logic idx_at_end;
        logic joins;
        logic out_free;
    } rcl_status_t;

endpackage

// ----- rtl/core/rcl_datapath.sv -----
`include "range_list_consolidator_defines.svh"

module rcl_datapath
    import rcl_pkg::*;
#(
    parameter int MAX_RANGES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  rcl_in_t     range_data,
    output rcl_out_t    merged_data,
    output logic        merged_valid,
    input  logic        merged_stall,
    input  rcl_cmd_t    cmd,
    output rcl_status_t status
);

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    logic [BOUND_W-1:0] lo_mem [MAX_RANGES];
    logic [BOUND_W-1:0] hi_mem [MAX_RANGES];

    logic [BOUND_W-1:0] item_lo_reg, item_lo_next;
    logic [BOUND_W-1:0] item_hi_reg, item_hi_next;
    logic               item_last_reg, item_last_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [BOUND_W-1:0] run_lo_reg, run_lo_next;
    logic [BOUND_W-1:0] run_hi_reg, run_hi_next;
    rcl_out_t           out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic [BOUND_W-1:0] rd_lo_reg;
    logic [BOUND_W-1:0] rd_hi_reg;

    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [BOUND_W-1:0] wr_lo;
    logic [BOUND_W-1:0] wr_hi;
    logic [BOUND_W:0]   run_hi_inc;

    assign rd_addr    = cmd.ins_read ? (pos_reg - AW'(1)) : idx_reg[AW-1:0];
    assign wr_en      = cmd.ins_shift | cmd.ins_place;
    assign wr_lo      = cmd.ins_shift ? rd_lo_reg : item_lo_reg;
    assign wr_hi      = cmd.ins_shift ? rd_hi_reg : item_hi_reg;
    assign run_hi_inc = {1'b0, run_hi_reg} + (BOUND_W + 1)'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lo_mem[pos_reg] <= wr_lo;
            hi_mem[pos_reg] <= wr_hi;
        end
        if (cmd.ins_read || cmd.mrg_read)
        begin
            rd_lo_reg <= lo_mem[rd_addr];
            rd_hi_reg <= hi_mem[rd_addr];
        end
    end

    always_comb
    begin
        status.item_ok      = item_lo_reg < item_hi_reg;
        status.item_last    = item_last_reg;
        status.full         = count_reg == CW'(MAX_RANGES);
        status.count_zero   = count_reg == '0;
        status.pos_zero     = pos_reg == '0;
        status.shift_needed = rd_lo_reg > item_lo_reg;
        status.idx_first    = idx_reg == '0;
        status.idx_at_end   = idx_reg == (count_reg - CW'(1));
        status.joins        = {1'b0, rd_lo_reg} <= run_hi_inc;
        status.out_free     = !out_valid_reg || !merged_stall;
    end

    always_comb
    begin
        item_lo_next   = item_lo_reg;
        item_hi_next   = item_hi_reg;
        item_last_next = item_last_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        run_lo_next    = run_lo_reg;
        run_hi_next    = run_hi_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load_item)
        begin
            item_lo_next   = range_data.range_lo;
            item_hi_next   = range_data.range_hi;
            item_last_next = range_data.is_last_in;
        end

        if (cmd.ins_start)
        begin
            pos_next = count_reg[AW-1:0];
        end
        else if (cmd.ins_shift)
        begin
            pos_next = pos_reg - AW'(1);
        end

        if (cmd.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            if (cmd.ins_place)
            begin
                count_next = count_reg + CW'(1);
            end
            if (cmd.set_ovf)
            begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.mrg_start)
        begin
            idx_next = '0;
        end
        else if (cmd.mrg_advance)
        begin
            idx_next = idx_reg + CW'(1);
        end

        if (cmd.run_load)
        begin
            run_lo_next = rd_lo_reg;
            run_hi_next = rd_hi_reg;
        end
        else if (cmd.run_ext && (rd_hi_reg > run_hi_reg))
        begin
            run_hi_next = rd_hi_reg;
        end

        if (cmd.emit)
        begin
            out_next.merged_lo   = cmd.emit_empty ? '0 : run_lo_reg;
            out_next.merged_hi   = cmd.emit_empty ? '0 : run_hi_reg;
            out_next.is_last_out = cmd.emit_last;
            out_next.is_empty    = cmd.emit_empty;
            out_next.overflowed  = ovf_reg;
            out_valid_next       = 1'b1;
        end
        else if (!merged_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_lo_reg   <= item_lo_next;
        item_hi_reg   <= item_hi_next;
        item_last_reg <= item_last_next;
        pos_reg       <= pos_next;
        idx_reg       <= idx_next;
        run_lo_reg    <= run_lo_next;
        run_hi_reg    <= run_hi_next;
        out_reg       <= out_next;
    end

    assign merged_data  = out_reg;
    assign merged_valid = out_valid_reg;

    `RCL_ASSERT_IMPLIES(a_emit_when_free, clk, rst_n, cmd.emit, status.out_free)
    `RCL_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_RANGES))
    `RCL_ASSERT_NEXT(a_place_count, clk, rst_n, cmd.ins_place, count_reg == $past(count_reg) + CW'(1))
    `RCL_ASSERT_NEXT(a_clear_state, clk, rst_n, cmd.clear, (count_reg == '0) && !ovf_reg)

endmodule

// ----- rtl/core/rcl_ctrl.sv -----
module rcl_ctrl
    import rcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        range_valid,
    output logic        range_stall,
    input  rcl_status_t status,
    output rcl_cmd_t    cmd
);

    rcl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (range_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.item_ok && !status.full)
                begin
                    state_next = ST_INS_RD;
                end
                else if (!status.item_last)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.count_zero)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    state_next = ST_MRG_RD;
                end
            end
            ST_INS_RD:
            begin
                if (!status.pos_zero)
                begin
                    state_next = ST_INS_CMP;
                end
                else
                begin
                    state_next = status.item_last ? ST_MRG_RD : ST_IDLE;
                end
            end
            ST_INS_CMP:
            begin
                if (status.shift_needed)
                begin
                    state_next = ST_INS_RD;
                end
                else
                begin
                    state_next = status.item_last ? ST_MRG_RD : ST_IDLE;
                end
            end
            ST_MRG_RD:
            begin
                state_next = ST_MRG_CMP;
            end
            ST_MRG_CMP:
            begin
                if (status.idx_first || status.joins)
                begin
                    state_next = status.idx_at_end ? ST_MRG_LAST : ST_MRG_RD;
                end
                else
                begin
                    state_next = ST_MRG_EMIT;
                end
            end
            ST_MRG_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.idx_at_end ? ST_MRG_LAST : ST_MRG_RD;
                end
            end
            ST_MRG_LAST, ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd         = '0;
        range_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                range_stall   = 1'b0;
                cmd.load_item = range_valid;
            end
            ST_DECIDE:
            begin
                if (status.item_ok && !status.full)
                begin
                    cmd.ins_start = 1'b1;
                end
                else
                begin
                    cmd.set_ovf   = status.item_ok;
                    cmd.mrg_start = status.item_last && !status.count_zero;
                end
            end
            ST_INS_RD:
            begin
                if (!status.pos_zero)
                begin
                    cmd.ins_read = 1'b1;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    cmd.mrg_start = status.item_last;
                end
            end
            ST_INS_CMP:
            begin
                if (status.shift_needed)
                begin
                    cmd.ins_shift = 1'b1;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    cmd.mrg_start = status.item_last;
                end
            end
            ST_MRG_RD:
            begin
                cmd.mrg_read = 1'b1;
            end
            ST_MRG_CMP:
            begin
                if (status.idx_first)
                begin
                    cmd.run_load    = 1'b1;
                    cmd.mrg_advance = !status.idx_at_end;
                end
                else if (status.joins)
                begin
                    cmd.run_ext     = 1'b1;
                    cmd.mrg_advance = !status.idx_at_end;
                end
            end
            ST_MRG_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.run_load    = 1'b1;
                    cmd.mrg_advance = !status.idx_at_end;
                end
            end
            ST_MRG_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.clear     = 1'b1;
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_last  = 1'b1;
                    cmd.emit_empty = 1'b1;
                    cmd.clear      = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/range_list_consolidator.sv -----
// range list consolidator
//
// input channel range_valid / range_stall / range_data carries one range per
// transaction; is_last_in closes the set. ranges with range_lo >= range_hi are
// dropped, ranges past MAX_RANGES are dropped and flagged on the results.
// each kept range is insertion-sorted by lower bound into a single-port store,
// every stored entry with a greater lower bound being shifted up; range_stall
// stays high until the range is placed or dropped and, on the last one, until
// the scan is done, so no new range is taken before that. on the last
// transaction the store is scanned once, and merged ranges go out on
// merged_valid / merged_stall / merged_data in ascending order, is_last_out
// on the final one. an empty set gives one result with is_empty set and zero
// bounds.
// results sit in one output register; a stalled receiver holds that register
// and the scan waits, while the next set may already be loaded once the scan
// is done. reset empties the store and drops any pending result; no clearing
// pass is needed.
module range_list_consolidator
    import rcl_pkg::*;
#(
    parameter int MAX_RANGES = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     range_valid,
    output logic     range_stall,
    input  rcl_in_t  range_data,
    output logic     merged_valid,
    input  logic     merged_stall,
    output rcl_out_t merged_data
);

    rcl_cmd_t    cmd;
    rcl_status_t status;

    rcl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .range_valid (range_valid),
        .range_stall (range_stall),
        .status      (status),
        .cmd         (cmd)
    );

    rcl_datapath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .range_data   (range_data),
        .merged_data  (merged_data),
        .merged_valid (merged_valid),
        .merged_stall (merged_stall),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
